### rtl/swrm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrm_pkg
// Types, widths and codes shared by the sliding window rate meter.
// ----------------------------------------------------------------------------
package swrm_pkg;

  localparam int TIME_W     = 32;
  localparam int AMT_W      = 32;
  localparam int BUCKET_W   = 32;
  localparam int RATE_W     = 32;
  localparam int LEN_W      = 5;
  localparam int TOT_W      = 36;
  // Up to 31 full buckets fit: bucket width plus window length width.
  localparam int SUM_W      = BUCKET_W + LEN_W;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 1;

  localparam int DEF_NUM_BUCKETS = 16;

  localparam logic [RATE_W-1:0] RATE_LIMIT_RESET = RATE_W'(2 * 1024);
  localparam logic [LEN_W-1:0]  WINDOW_LEN_RESET = LEN_W'(15);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RATE_LIMIT,
    REG_WINDOW_LEN
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADV,
    ST_ADD_RD,
    ST_ADD_WR
  } state_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic inval;
    logic clr_all;
  } mem_cmd_t;

endpackage

### rtl/swrm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrm_in_if / swrm_out_if
// Valid/ready channels for sample words and report words.
// ----------------------------------------------------------------------------
interface swrm_in_if;
  import swrm_pkg::*;

  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] now_seconds;
  logic [AMT_W-1:0]  amount;

  modport source (output valid, output now_seconds, output amount, input ready);
  modport sink   (input valid, input now_seconds, input amount, output ready);
endinterface

interface swrm_out_if;
  import swrm_pkg::*;

  logic             valid;
  logic             ready;
  logic             within_limit;
  logic [TOT_W-1:0] window_total;

  modport source (output valid, output within_limit, output window_total, input ready);
  modport sink   (input valid, input within_limit, input window_total, output ready);
endinterface

### rtl/swrm_bucket_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrm_bucket_mem
// Bucket store: synchronous RAM with one write and one read port, plus a
// valid bit per entry so that a whole clear needs no pass over the entries.
// ----------------------------------------------------------------------------
module swrm_bucket_mem #(
  parameter int NUM_BUCKETS = swrm_pkg::DEF_NUM_BUCKETS,
  parameter int IDX_W       = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  swrm_pkg::mem_cmd_t            cmd,
  input  logic [IDX_W-1:0]              rd_addr,
  input  logic [IDX_W-1:0]              wr_addr,
  input  logic [swrm_pkg::BUCKET_W-1:0] wr_data,
  output logic [swrm_pkg::BUCKET_W-1:0] rd_data
);
  import swrm_pkg::*;

  logic [BUCKET_W-1:0]    mem [NUM_BUCKETS];
  logic [NUM_BUCKETS-1:0] valid;
  logic [BUCKET_W-1:0]    rd_raw;
  logic                   rd_valid;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_raw   <= mem[rd_addr];
      rd_valid <= valid[rd_addr];
    end
  end

  // Invalidate and write share the write address; they never happen together.
  always_ff @(posedge clk) begin
    if (rst || cmd.clr_all) begin
      valid <= '0;
    end else begin
      if (cmd.inval) begin
        valid[wr_addr] <= 1'b0;
      end
      if (cmd.wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
    end
  end

  // An entry that was cleared reads as zero.
  assign rd_data = rd_valid ? rd_raw : '0;

endmodule

### rtl/swrm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrm_ctrl
// Sequencer for one sample word: ring advance with read/modify, bucket
// update, running window total and the report register.
// ----------------------------------------------------------------------------
module swrm_ctrl #(
  parameter int IDX_W = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_clear,
  input  logic [swrm_pkg::RATE_W-1:0]   rate_limit,
  input  logic [swrm_pkg::LEN_W-1:0]    eff_len,
  swrm_in_if.sink                       sample,
  swrm_out_if.source                    report,
  output swrm_pkg::mem_cmd_t            cmd,
  output logic [IDX_W-1:0]              rd_addr,
  output logic [IDX_W-1:0]              wr_addr,
  output logic [swrm_pkg::BUCKET_W-1:0] wr_data,
  input  logic [swrm_pkg::BUCKET_W-1:0] rd_data
);
  import swrm_pkg::*;

  localparam int CMP_W = (IDX_W > LEN_W) ? IDX_W : LEN_W;

  state_t            state, state_next;
  logic [IDX_W-1:0]  idx, idx_next, idx_inc;
  logic [SUM_W-1:0]  sum, sum_next;
  logic [TIME_W-1:0] stamp, stamp_next;
  logic [AMT_W-1:0]  amt, amt_next;
  logic [LEN_W-1:0]  cnt, cnt_next;
  logic              pend, pend_next;
  logic              out_load;

  logic [TIME_W-1:0]   diff;
  logic [LEN_W-1:0]    elapsed;
  logic [LEN_W-1:0]    len_m1;
  logic [BUCKET_W-1:0] room, take;

  always_comb begin
    len_m1 = eff_len - LEN_W'(1);
    if (CMP_W'(idx) == CMP_W'(len_m1)) begin
      idx_inc = '0;
    end else begin
      idx_inc = idx + IDX_W'(1);
    end

    // A timestamp that goes backwards counts as no time elapsed.
    diff = sample.now_seconds - stamp;
    if (sample.now_seconds < stamp) begin
      elapsed = '0;
    end else if (diff > TIME_W'(eff_len)) begin
      elapsed = eff_len;
    end else begin
      elapsed = diff[LEN_W-1:0];
    end

    room = ~rd_data;
    take = (amt > room) ? room : amt;
  end

  always_comb begin
    state_next   = state;
    idx_next     = idx;
    sum_next     = sum;
    stamp_next   = stamp;
    amt_next     = amt;
    cnt_next     = cnt;
    pend_next    = pend;
    out_load     = 1'b0;
    cmd          = '0;
    cmd.clr_all  = cfg_clear;
    rd_addr      = idx;
    wr_addr      = idx;
    wr_data      = rd_data + take;
    sample.ready = 1'b0;

    unique case (state)
      ST_IDLE: begin
        sample.ready = ~rst;
        if (sample.valid) begin
          amt_next = sample.amount;
          if (elapsed != '0) begin
            stamp_next = sample.now_seconds;
            cnt_next   = elapsed;
            pend_next  = 1'b0;
            state_next = ST_ADV;
          end else begin
            state_next = ST_ADD_RD;
          end
        end
      end
      ST_ADV: begin
        // Retire the bucket read last cycle while the next one is read.
        if (pend) begin
          sum_next  = sum - SUM_W'(rd_data);
          cmd.inval = 1'b1;
        end
        if (cnt != '0) begin
          cmd.rd_en = 1'b1;
          rd_addr   = idx_inc;
          idx_next  = idx_inc;
          cnt_next  = cnt - LEN_W'(1);
          pend_next = 1'b1;
        end else begin
          pend_next  = 1'b0;
          state_next = ST_ADD_RD;
        end
      end
      ST_ADD_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = ST_ADD_WR;
      end
      ST_ADD_WR: begin
        if (!report.valid || report.ready) begin
          cmd.wr_en  = 1'b1;
          sum_next   = sum + SUM_W'(take);
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_clear) begin
      idx   <= '0;
      sum   <= '0;
      stamp <= '0;
    end else begin
      idx   <= idx_next;
      sum   <= sum_next;
      stamp <= stamp_next;
    end
  end

  always_ff @(posedge clk) begin
    amt  <= amt_next;
    cnt  <= cnt_next;
    pend <= pend_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      report.valid <= 1'b0;
    end else if (out_load) begin
      report.valid <= 1'b1;
    end else if (report.ready) begin
      report.valid <= 1'b0;
    end
  end

  // The flag uses the exact total; the shown total saturates.
  always_ff @(posedge clk) begin
    if (out_load) begin
      report.within_limit <= (sum_next < SUM_W'(rate_limit));
      if (|sum_next[SUM_W-1:TOT_W]) begin
        report.window_total <= '1;
      end else begin
        report.window_total <= sum_next[TOT_W-1:0];
      end
    end
  end

endmodule

### rtl/sliding_window_rate_meter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_rate_meter_top
// Windowed byte rate meter over a ring of one-second buckets.
// ----------------------------------------------------------------------------
// Each sample word (now_seconds, amount) yields one report word with the
// window total and a within-limit flag. A sample that lands in the current
// second only reads and rewrites its bucket; one that moves the ring by e
// seconds (e capped at the window length) first retires every passed bucket,
// read through the single read port of the bucket RAM, one bucket per cycle.
// No new sample is taken until the last one is through. A finished
// report waits in an output register; the sample side is accepted again
// while it waits. Reset and a write of window_len clear the whole store
// via per-entry valid bits, so there is no clearing pass.
module sliding_window_rate_meter_top #(
  parameter int NUM_BUCKETS = swrm_pkg::DEF_NUM_BUCKETS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [swrm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [swrm_pkg::CFG_DATA_W-1:0] cfg_data,
  swrm_in_if.sink                         sample,
  swrm_out_if.source                      report
);
  import swrm_pkg::*;

  localparam int IDX_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;

  logic [RATE_W-1:0]   rate_limit;
  logic [LEN_W-1:0]    window_len;
  logic [LEN_W-1:0]    eff_len;
  logic                cfg_clear;
  mem_cmd_t            cmd;
  logic [IDX_W-1:0]    rd_addr, wr_addr;
  logic [BUCKET_W-1:0] wr_data, rd_data;

  assign cfg_clear = cfg_we && (cfg_reg_t'(cfg_index) == REG_WINDOW_LEN);

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_limit <= RATE_LIMIT_RESET;
      window_len <= WINDOW_LEN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_RATE_LIMIT: rate_limit <= cfg_data[RATE_W-1:0];
        REG_WINDOW_LEN: window_len <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (window_len == '0) begin
      eff_len = LEN_W'(1);
    end else if (32'(window_len) > NUM_BUCKETS) begin
      eff_len = LEN_W'(NUM_BUCKETS);
    end else begin
      eff_len = window_len;
    end
  end

  swrm_ctrl #(
    .IDX_W (IDX_W)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_clear  (cfg_clear),
    .rate_limit (rate_limit),
    .eff_len    (eff_len),
    .sample     (sample),
    .report     (report),
    .cmd        (cmd),
    .rd_addr    (rd_addr),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_data    (rd_data)
  );

  swrm_bucket_mem #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .IDX_W       (IDX_W)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

endmodule

### rtl/swrm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrm_checker
// Port-level checks of the rate meter, bound to the top level.
// ----------------------------------------------------------------------------
module swrm_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         out_within,
  input logic [swrm_pkg::TOT_W-1:0]   out_total
);
  import swrm_pkg::*;

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // In the cycle after a sample word is accepted, the input is not ready.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !in_ready)
    else $error("sample accepted in the cycle after an accept");

  // A report cannot appear before its sample has passed the bucket read and write states.
  a_report_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (!$past(in_acc, 1) && !$past(in_acc, 2)))
    else $error("report word appeared too soon after a sample word");

  a_report_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("report word dropped while stalled");

  a_report_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_within) && $stable(out_total))
    else $error("report payload changed while stalled");

endmodule

bind sliding_window_rate_meter_top swrm_checker u_swrm_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (sample.valid),
  .in_ready   (sample.ready),
  .out_valid  (report.valid),
  .out_ready  (report.ready),
  .out_within (report.within_limit),
  .out_total  (report.window_total)
);
